// ===== design/lag_pkg.sv =====
package lag_pkg;

    // default board size
    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    // request field widths
    localparam int OPCODE_W = 3;
    localparam int COORD_W  = 6;

    // neighbour counts of the b3/s23 rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    // request opcodes, unused codes behave as a read
    typedef enum logic [OPCODE_W-1:0] {
        OP_READ  = 3'd0,
        OP_SET   = 3'd1,
        OP_KILL  = 3'd2,
        OP_STEP  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    // row memory read address source
    typedef enum logic {
        RD_COORD,
        RD_SWEEP
    } rd_src_t;

    // row memory write source
    typedef enum logic [1:0] {
        WR_ZERO,
        WR_MODIFY,
        WR_LIFE
    } wr_src_t;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_STEP,
        ST_CLEAR,
        ST_READ,
        ST_MODIFY,
        ST_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_en;
        wr_src_t wr_src;
        logic    win_clear;
        logic    win_shift;
        logic    below_zero;
        logic    res_load;
        logic    out_load;
    } lag_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        op_t  op_code;
        logic in_grid;
    } lag_status_t;

    // b3/s23 next state of one cell
    function automatic logic next_cell(input logic alive, input logic [3:0] count);
        logic born;
        logic keep;
        born = (count == BIRTH_COUNT);
        keep = alive && (count == SURVIVE_LOW);
        return born || keep;
    endfunction

endpackage

// ===== design/lag_ctrl.sv =====
module lag_ctrl
#(
    parameter int GRID_HEIGHT = lag_pkg::GRID_HEIGHT_DEF,
    localparam int CNT_W = $clog2(GRID_HEIGHT + 2)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lag_pkg::lag_status_t status,
    output lag_pkg::lag_cmd_t    cmd,
    output logic [CNT_W-1:0]     sweep_cnt
);
    import lag_pkg::*;

    localparam logic [CNT_W-1:0] LAST_ROW  = CNT_W'(GRID_HEIGHT - 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GRID_HEIGHT + 1);
    localparam logic [CNT_W-1:0] FIRST_WR  = CNT_W'(2);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // state, sweep counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_ZERO;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cnt_next = '0;
                if (status.op_code == OP_STEP)
                begin
                    state_next = ST_STEP;
                end
                else if (status.op_code == OP_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WR_ZERO;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STEP:
            begin
                // read row n, write new row n-2 from the three-row window
                cmd.rd_en      = (cnt_reg <= LAST_ROW);
                cmd.rd_src     = RD_SWEEP;
                cmd.win_clear  = (cnt_reg == '0);
                cmd.win_shift  = (cnt_reg != '0);
                cmd.wr_en      = (cnt_reg >= FIRST_WR);
                cmd.wr_src     = WR_LIFE;
                cmd.below_zero = (cnt_reg == LAST_STEP);
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_COORD;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                cmd.res_load = 1'b1;
                cmd.wr_src   = WR_MODIFY;
                cmd.wr_en    = status.in_grid &&
                               ((status.op_code == OP_SET) || (status.op_code == OP_KILL));
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sweep_cnt = cnt_reg;

endmodule

// ===== design/lag_datapath.sv =====
module lag_datapath
#(
    parameter int GRID_WIDTH  = lag_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lag_pkg::GRID_HEIGHT_DEF,
    localparam int CNT_W = $clog2(GRID_HEIGHT + 2),
    localparam int ROW_W = $clog2(GRID_HEIGHT),
    localparam int COL_W = $clog2(GRID_WIDTH)
)
(
    input  logic                          clk,
    input  lag_pkg::lag_cmd_t             cmd,
    input  logic [CNT_W-1:0]              sweep_cnt,
    input  logic [lag_pkg::OPCODE_W-1:0]  opcode,
    input  logic [lag_pkg::COORD_W-1:0]   x_coord,
    input  logic [lag_pkg::COORD_W-1:0]   y_coord,
    output lag_pkg::lag_status_t          status,
    output logic                          cell_alive
);
    import lag_pkg::*;

    op_t                   op_reg;
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [GRID_WIDTH-1:0] cell_grid_mem [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] rd_data_reg;
    logic [GRID_WIDTH-1:0] above_reg;
    logic [GRID_WIDTH-1:0] mid_reg;
    logic                  res_reg;
    logic                  res_next;
    logic                  cell_alive_reg;

    logic                  in_grid;
    logic [ROW_W-1:0]      coord_row;
    logic [COL_W-1:0]      col_idx;
    logic [GRID_WIDTH-1:0] col_mask;
    logic [ROW_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      life_cnt;
    logic [ROW_W-1:0]      wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;
    logic [GRID_WIDTH-1:0] below_row;
    logic [GRID_WIDTH-1:0] mod_row;
    logic [GRID_WIDTH-1:0] life_row;
    logic [GRID_WIDTH+1:0] above_ext;
    logic [GRID_WIDTH+1:0] mid_ext;
    logic [GRID_WIDTH+1:0] below_ext;
    logic [3:0]            nb_count;

    // addressed cell decode
    assign in_grid   = (32'(x_reg) < GRID_WIDTH) && (32'(y_reg) < GRID_HEIGHT);
    assign coord_row = in_grid ? ROW_W'(y_reg) : '0;
    assign col_idx   = COL_W'(x_reg);
    assign col_mask  = GRID_WIDTH'(1) << col_idx;

    // read address, write target lags the sweep by two rows
    assign rd_addr  = (cmd.rd_src == RD_SWEEP) ? sweep_cnt[ROW_W-1:0] : coord_row;
    assign life_cnt = sweep_cnt - CNT_W'(2);

    // set or kill applied to the fetched row
    always_comb
    begin
        if (op_reg == OP_SET)
        begin
            mod_row = rd_data_reg | col_mask;
        end
        else if (op_reg == OP_KILL)
        begin
            mod_row = rd_data_reg & ~col_mask;
        end
        else
        begin
            mod_row = rd_data_reg;
        end
    end

    assign res_next = in_grid && mod_row[col_idx];

    // next generation of the middle window row, borders read as dead
    assign below_row = cmd.below_zero ? '0 : rd_data_reg;
    assign above_ext = {1'b0, above_reg, 1'b0};
    assign mid_ext   = {1'b0, mid_reg, 1'b0};
    assign below_ext = {1'b0, below_row, 1'b0};

    always_comb
    begin
        nb_count = '0;
        life_row = '0;
        for (int c = 0; c < GRID_WIDTH; c++)
        begin
            nb_count = 4'(above_ext[c]) + 4'(above_ext[c+1]) + 4'(above_ext[c+2])
                     + 4'(mid_ext[c]) + 4'(mid_ext[c+2])
                     + 4'(below_ext[c]) + 4'(below_ext[c+1]) + 4'(below_ext[c+2]);
            life_row[c] = next_cell(mid_ext[c+1], nb_count);
        end
    end

    // write port select
    always_comb
    begin
        unique case (cmd.wr_src)
            WR_ZERO:
            begin
                wr_addr = sweep_cnt[ROW_W-1:0];
                wr_data = '0;
            end
            WR_MODIFY:
            begin
                wr_addr = coord_row;
                wr_data = mod_row;
            end
            WR_LIFE:
            begin
                wr_addr = life_cnt[ROW_W-1:0];
                wr_data = life_row;
            end
            default:
            begin
                wr_addr = '0;
                wr_data = '0;
            end
        endcase
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg <= op_t'(opcode);
            x_reg  <= x_coord;
            y_reg  <= y_coord;
        end
    end

    // row memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            cell_grid_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= cell_grid_mem[rd_addr];
        end
    end

    // three-row window
    always_ff @(posedge clk)
    begin
        if (cmd.win_clear)
        begin
            above_reg <= '0;
            mid_reg   <= '0;
        end
        else if (cmd.win_shift)
        begin
            above_reg <= mid_reg;
            mid_reg   <= below_row;
        end
    end

    // result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            cell_alive_reg <= res_reg;
        end
    end

    assign status.op_code = op_reg;
    assign status.in_grid = in_grid;
    assign cell_alive     = cell_alive_reg;

endmodule

// ===== design/life_automaton_grid.sv =====
// life grid, b3/s23 on GRID_WIDTH x GRID_HEIGHT cells held as one memory row per grid row
// flow: read, set and kill take the request, fetch its row, modify it and register the result;
// clear first zeroes every row, step first sweeps the rows through the single memory read port
// requests: one at a time, the next is taken once the result is registered,
// and a result stalled by out_ready holds off the next request
// reset: async active low; a clearing pass over all GRID_HEIGHT rows follows, in_ready stays low
module life_automaton_grid
#(
    parameter int GRID_WIDTH  = lag_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lag_pkg::GRID_HEIGHT_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lag_pkg::OPCODE_W-1:0] opcode,
    input  logic [lag_pkg::COORD_W-1:0]  x_coord,
    input  logic [lag_pkg::COORD_W-1:0]  y_coord,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         cell_alive
);
    import lag_pkg::*;

    localparam int CNT_W = $clog2(GRID_HEIGHT + 2);

    lag_cmd_t         cmd;
    lag_status_t      status;
    logic [CNT_W-1:0] sweep_cnt;

    // sequencer
    lag_ctrl #(
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .sweep_cnt (sweep_cnt)
    );

    // grid memory and generation logic
    lag_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .sweep_cnt  (sweep_cnt),
        .opcode     (opcode),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .status     (status),
        .cell_alive (cell_alive)
    );

endmodule

// ===== design/lag_checker.sv =====
module lag_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cell_alive
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_alive))
        else $error("result changed or dropped while stalled");

    // one request in flight at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    // no result sooner than the fetch path allows
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
        else $error("result appeared too early");

    // board clearing pass after reset
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request taken before the board was cleared");

endmodule

bind life_automaton_grid lag_checker u_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import lag_pkg::*;

    localparam int GRID_W       = GRID_WIDTH_DEF;
    localparam int GRID_H       = GRID_HEIGHT_DEF;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_REQS  = 550;
    localparam int IDLE_PCT     = 33;
    localparam int HOLD_CYCLES  = 160;
    localparam int HOLD_AT      = 120;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 400;
    localparam int WIN          = 8;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;
    localparam int LIMIT_NS     = 10_000_000;

    // highest opcode value, unused codes sit between OP_CLEAR and this one
    localparam logic [OPCODE_W-1:0] OP_TOP = '1;

    // board predictor with the queue of expected cell states
    class life_board;
        bit [GRID_W-1:0] cells [GRID_H];
        bit              alive_expected [$];
        int              errors;
        int              requests;
        int              steps;
        int              clears;
        int              checked;

        function bit cell_live(int x, int y);
            if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
                return 1'b0;
            return cells[y][x];
        endfunction

        // b3/s23 generation computed from the old board only
        function void evolve();
            bit [GRID_W-1:0] fresh [GRID_H];
            int              n;
            for (int y = 0; y < GRID_H; y++)
            begin
                for (int x = 0; x < GRID_W; x++)
                begin
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if (dx != 0 || dy != 0)
                                n += cell_live(x + dx, y + dy);
                    fresh[y][x] = (n == int'(BIRTH_COUNT)) ||
                                  (cells[y][x] && n == int'(SURVIVE_LOW));
                end
            end
            cells = fresh;
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y);
            bit on_board;
            on_board = (int'(x) < GRID_W) && (int'(y) < GRID_H);
            requests++;
            case (op)
                OP_SET:
                    if (on_board)
                        cells[y][x] = 1'b1;
                OP_KILL:
                    if (on_board)
                        cells[y][x] = 1'b0;
                OP_STEP:
                begin
                    evolve();
                    steps++;
                end
                OP_CLEAR:
                begin
                    foreach (cells[i])
                        cells[i] = '0;
                    clears++;
                end
                default:
                    ;
            endcase
            alive_expected.push_back(cell_live(int'(x), int'(y)));
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic alive);
            bit want;
            if (alive_expected.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            want = alive_expected.pop_front();
            checked++;
            if (alive !== want)
                report($sformatf("cell_alive %b, expected %b", alive, want));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic                out_valid;
    logic                out_ready;
    logic                cell_alive;

    life_board board;
    logic      quiet;
    logic      hold_req;
    int        issued;

    life_automaton_grid #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_alive (cell_alive)
    );

    // clock
    always #(CLK_HALF) clk = ~clk;

    // result side: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_req = 1'b0;
        end
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // handshake monitor, sampled mid-cycle where everything is settled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(cell_alive);
            if (in_valid && in_ready)
                board.note_request(opcode, x_coord, y_coord);
        end
    end

    // offer one request and hold it until taken
    task automatic send_request(input logic [OPCODE_W-1:0] op, input int x, input int y);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        x_coord  <= COORD_W'(x);
        y_coord  <= COORD_W'(y);
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        issued++;
    endtask

    // window origin, biased toward the board edges
    function automatic int pick_origin(int extent);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 0;
        if (r == 1)
            return extent - WIN;
        return $urandom_range(0, extent - WIN);
    endfunction

    // seed a small window, let it evolve and look around
    task automatic run_pattern();
        int wx;
        int wy;
        wx = pick_origin(GRID_W);
        wy = pick_origin(GRID_H);
        repeat ($urandom_range(3, 12))
            send_request(($urandom_range(0, 7) == 0) ? OP_KILL : OP_SET,
                         wx + $urandom_range(0, WIN - 1), wy + $urandom_range(0, WIN - 1));
        repeat ($urandom_range(1, 4))
        begin
            send_request(OP_STEP, wx + $urandom_range(0, WIN - 1),
                         wy + $urandom_range(0, WIN - 1));
            send_request(OP_READ, wx + $urandom_range(0, WIN - 1),
                         wy + $urandom_range(0, WIN - 1));
        end
        if ($urandom_range(0, 9) == 0)
            send_request(OP_CLEAR, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    endtask

    initial
    begin
        int   total;
        logic held;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = '0;
        x_coord   = '0;
        y_coord   = '0;
        out_ready = 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        held      = 1'b0;
        issued    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty board, corners, kill
        send_request(OP_READ, 0, 0);
        send_request(OP_SET, 0, 0);
        send_request(OP_READ, 0, 0);
        send_request(OP_SET, GRID_W - 1, GRID_H - 1);
        send_request(OP_SET, GRID_W - 1, 0);
        send_request(OP_SET, 0, GRID_H - 1);
        send_request(OP_KILL, GRID_W - 1, 0);
        send_request(OP_READ, GRID_W - 1, 0);

        // unused opcodes act as a read
        send_request(OP_TOP, GRID_W - 1, GRID_H - 1);
        send_request(OPCODE_W'(OP_TOP - 1), 0, 0);
        send_request(OPCODE_W'(OP_CLEAR + 1), 5, 5);

        // blinker on the top row, one of its cells falls off the board
        send_request(OP_SET, 10, 0);
        send_request(OP_SET, 11, 0);
        send_request(OP_SET, 12, 0);
        send_request(OP_STEP, 11, 1);
        send_request(OP_STEP, 11, 0);

        // three cells in the far corner grow into a block
        send_request(OP_SET, GRID_W - 2, GRID_H - 2);
        send_request(OP_SET, GRID_W - 1, GRID_H - 2);
        send_request(OP_SET, GRID_W - 2, GRID_H - 1);
        send_request(OP_STEP, GRID_W - 1, GRID_H - 1);

        // clear whatever the coordinates
        send_request(OP_CLEAR, 11, 0);
        send_request(OP_READ, GRID_W - 1, GRID_H - 1);

        // random part: mostly seeded windows, some noise
        total = issued + RANDOM_REQS;
        while (issued < total)
        begin
            quiet = (issued >= total - RANDOM_REQS + QUIET_FROM) &&
                    (issued <  total - RANDOM_REQS + QUIET_TO);
            // one long result hold-off while requests keep coming
            if (!held && issued >= total - RANDOM_REQS + HOLD_AT)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if ($urandom_range(0, 99) < 70)
                run_pattern();
            else
                send_request(OPCODE_W'($urandom_range(0, OP_TOP)),
                             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // drain
        while (board.alive_expected.size() != 0)
            @(posedge clk);
        repeat (GRID_H + 16) @(posedge clk);

        $display("covered %0d requests: %0d generation steps, %0d board clears",
                 board.requests, board.steps, board.clears);
        $display("%0d cell states checked, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", board.alive_expected.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
design/lag_pkg.sv
design/lag_ctrl.sv
design/lag_datapath.sv
design/life_automaton_grid.sv
design/lag_checker.sv
dv/tb.sv
